>>> rtl/core/edm_pkg.sv
// ----------------------------------------------------------------------------
// edm_pkg
// Shared types and constants for the event decision matrix core.
// ----------------------------------------------------------------------------
package edm_pkg;

    localparam int ROWS_DEFAULT         = 8;
    localparam int MATRIX_BASE_DEFAULT  = 16;
    localparam int ZONE_ADDR_DEFAULT    = 0;
    localparam int SUBZONE_ADDR_DEFAULT = 1;

    localparam int ROW_BYTES = 8;

    // row byte offsets
    localparam int OFS_ORIGIN = 0;
    localparam int OFS_FLAGS  = 1;
    localparam int OFS_CMASK  = 2;
    localparam int OFS_CFILT  = 3;
    localparam int OFS_TMASK  = 4;
    localparam int OFS_TFILT  = 5;
    localparam int OFS_ACTION = 6;

    // flag bits
    localparam int FLG_ENABLE = 7;
    localparam int FLG_ORIGIN = 6;
    localparam int FLG_ZONE   = 4;
    localparam int FLG_MASK8  = 1;
    localparam int FLG_FILT8  = 0;

    localparam logic [7:0] READ_ERR_VALUE = 8'hFF;

    typedef enum logic [1:0] {
        CMD_EVENT  = 2'd0,
        CMD_WRITE  = 2'd1,
        CMD_READ   = 2'd2,
        CMD_UNUSED = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        KIND_ACTION = 2'd0,
        KIND_REG    = 2'd1,
        KIND_DONE   = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RESP,
        ST_SCAN,
        ST_DONE
    } state_t;

endpackage

>>> rtl/core/event_decision_matrix_core.sv
// ----------------------------------------------------------------------------
// event_decision_matrix_core
// Register file with zone, subzone and decision-matrix rows; matches events
// against enabled rows and emits one action item per matching row.
// ----------------------------------------------------------------------------
// Register access: the result of a write or read passes from the accepting
//   edge through ST_RESP into the output register, where it can be taken.
// Throughput: one input item at a time; an event reads one row per cycle from
//   the row memory, stalling on a matching row while the output slot is full,
//   then emits the done item; a class zero event only emits the done item.
// Reset: synchronous, active low; zone, subzone and all row bytes read as 0.
// ----------------------------------------------------------------------------
module event_decision_matrix_core
    import edm_pkg::*;
#(
    parameter int ROWS         = ROWS_DEFAULT,
    parameter int MATRIX_BASE  = MATRIX_BASE_DEFAULT,
    parameter int ZONE_ADDR    = ZONE_ADDR_DEFAULT,
    parameter int SUBZONE_ADDR = SUBZONE_ADDR_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // reg_addr[6:0], reg_data[14:7], event_class[23:15],
    // event_type[31:24], origin_addr[39:32], event_zone[47:40]
    input  logic [47:0] s_tdata,
    // cmd[1:0]
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // row_index[2:0], action_code[10:3], reg_value[18:11]
    output logic [23:0] m_tdata,
    // kind[1:0]
    output logic [1:0]  m_tuser,
    output logic        m_tlast
);

    localparam int RW       = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int SB_W     = RW + 3;
    localparam int NBYTES   = ROWS * ROW_BYTES;
    localparam logic [RW-1:0] LAST_ROW = RW'(ROWS - 1);

    // input fields
    logic [1:0] in_cmd;
    logic [6:0] in_addr;
    logic [7:0] in_data;
    logic [8:0] in_class;
    logic [7:0] in_type;
    logic [7:0] in_origin;
    logic [7:0] in_zone;

    assign in_cmd    = s_tuser;
    assign in_addr   = s_tdata[6:0];
    assign in_data   = s_tdata[14:7];
    assign in_class  = s_tdata[23:15];
    assign in_type   = s_tdata[31:24];
    assign in_origin = s_tdata[39:32];
    assign in_zone   = s_tdata[47:40];

    // state
    state_t          state_reg, state_next;
    logic [RW-1:0]   row_reg, row_next;
    logic [8:0]      ev_class_reg;
    logic [7:0]      ev_type_reg, ev_origin_reg, ev_zone_reg;
    logic [7:0]      resp_val_reg;
    logic            from_ram_reg;
    logic [2:0]      byte_sel_reg;
    logic [7:0]      zone_reg, subzone_reg;
    logic [NBYTES-1:0] vld_reg;

    // row memory
    logic [63:0]     mem [ROWS];
    logic [63:0]     ram_q_reg;
    logic [7:0]      vld_q_reg;

    // output register
    logic            out_vld_reg, out_vld_next;
    kind_t           out_kind_reg;
    logic [2:0]      out_row_reg;
    logic [7:0]      out_act_reg, out_val_reg;
    logic            out_last_reg;

    logic            out_load;
    kind_t           ld_kind;
    logic [2:0]      ld_row;
    logic [7:0]      ld_act, ld_val;
    logic            ld_last;

    // address decode
    logic            accept, slot_free;
    logic            hit_zone, hit_subzone, hit_matrix;
    logic [6:0]      mofs;
    logic [RW-1:0]   a_row;
    logic [2:0]      a_byte;

    assign accept    = s_tvalid && s_tready;
    assign slot_free = !out_vld_reg || m_tready;

    assign hit_zone    = (in_addr == 7'(ZONE_ADDR));
    assign hit_subzone = (in_addr == 7'(SUBZONE_ADDR));
    assign hit_matrix  = ({1'b0, in_addr} >= 8'(MATRIX_BASE)) &&
                         ({1'b0, in_addr} < 8'(MATRIX_BASE + NBYTES));
    assign mofs        = in_addr - 7'(MATRIX_BASE);
    assign a_row       = mofs[RW+2:3];
    assign a_byte      = mofs[2:0];

    // memory controls
    logic            mem_we, rd_en;
    logic [RW-1:0]   rd_row;

    assign mem_we = accept && (in_cmd == CMD_WRITE) && !hit_zone && !hit_subzone
                    && hit_matrix;

    // row view with never-written bytes reading as zero
    logic [63:0] row_w;
    always_comb begin
        for (int k = 0; k < ROW_BYTES; k++) begin
            row_w[k*8 +: 8] = ram_q_reg[k*8 +: 8] & {8{vld_q_reg[k]}};
        end
    end

    logic [7:0] r_origin, r_flags, r_action;
    logic [8:0] r_cmask, r_cfilt;
    logic [7:0] r_tmask, r_tfilt;
    logic       row_match;

    assign r_origin = row_w[OFS_ORIGIN*8 +: 8];
    assign r_flags  = row_w[OFS_FLAGS*8 +: 8];
    assign r_cmask  = {r_flags[FLG_MASK8], row_w[OFS_CMASK*8 +: 8]};
    assign r_cfilt  = {r_flags[FLG_FILT8], row_w[OFS_CFILT*8 +: 8]};
    assign r_tmask  = row_w[OFS_TMASK*8 +: 8];
    assign r_tfilt  = row_w[OFS_TFILT*8 +: 8];
    assign r_action = row_w[OFS_ACTION*8 +: 8];

    assign row_match = r_flags[FLG_ENABLE]
                    && !(r_flags[FLG_ORIGIN] && (ev_origin_reg != r_origin))
                    && !(r_flags[FLG_ZONE] && (ev_zone_reg != zone_reg))
                    && (((r_cfilt ^ ev_class_reg) & r_cmask) == 9'd0)
                    && (((r_tfilt ^ ev_type_reg) & r_tmask) == 8'd0);

    // next state and outputs
    always_comb begin
        state_next = state_reg;
        row_next   = row_reg;
        rd_en      = 1'b0;
        rd_row     = '0;
        out_load   = 1'b0;
        ld_kind    = KIND_DONE;
        ld_row     = 3'd0;
        ld_act     = 8'd0;
        ld_val     = 8'd0;
        ld_last    = 1'b1;
        s_tready   = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    unique case (in_cmd)
                        CMD_EVENT: begin
                            row_next = '0;
                            if (in_class != 9'd0) begin
                                rd_en      = 1'b1;
                                state_next = ST_SCAN;
                            end else begin
                                state_next = ST_DONE;
                            end
                        end
                        CMD_WRITE: begin
                            state_next = ST_RESP;
                        end
                        CMD_READ: begin
                            rd_row     = a_row;
                            rd_en      = hit_matrix;
                            state_next = ST_RESP;
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_RESP: begin
                ld_kind = KIND_REG;
                ld_val  = from_ram_reg ? row_w[{byte_sel_reg, 3'b000} +: 8]
                                       : resp_val_reg;
                if (slot_free) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_SCAN: begin
                ld_kind = KIND_ACTION;
                ld_row  = 3'(row_reg);
                ld_act  = r_action;
                ld_last = 1'b0;
                if (!row_match || slot_free) begin
                    out_load = row_match;
                    if (row_reg == LAST_ROW) begin
                        state_next = ST_DONE;
                    end else begin
                        row_next = row_reg + 1'b1;
                        rd_row   = row_reg + 1'b1;
                        rd_en    = 1'b1;
                    end
                end
            end
            ST_DONE: begin
                if (slot_free) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_vld_next = out_load ? 1'b1 : (m_tready ? 1'b0 : out_vld_reg);

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            row_reg     <= '0;
            out_vld_reg <= 1'b0;
            zone_reg    <= 8'd0;
            subzone_reg <= 8'd0;
            vld_reg     <= '0;
        end else begin
            state_reg   <= state_next;
            row_reg     <= row_next;
            out_vld_reg <= out_vld_next;
            if (accept && (in_cmd == CMD_WRITE)) begin
                if (hit_zone) begin
                    zone_reg <= in_data;
                end else if (hit_subzone) begin
                    subzone_reg <= in_data;
                end
            end
            if (mem_we) begin
                vld_reg[SB_W'({a_row, a_byte})] <= 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            ev_class_reg  <= in_class;
            ev_type_reg   <= in_type;
            ev_origin_reg <= in_origin;
            ev_zone_reg   <= in_zone;
            byte_sel_reg  <= a_byte;
            from_ram_reg  <= (in_cmd == CMD_READ) && !hit_zone && !hit_subzone
                             && hit_matrix;
            if (in_cmd == CMD_WRITE) begin
                resp_val_reg <= (hit_zone || hit_subzone || hit_matrix) ? in_data
                                                                        : ~in_data;
            end else if (hit_zone) begin
                resp_val_reg <= zone_reg;
            end else if (hit_subzone) begin
                resp_val_reg <= subzone_reg;
            end else begin
                resp_val_reg <= READ_ERR_VALUE;
            end
        end
        if (out_load) begin
            out_kind_reg <= ld_kind;
            out_row_reg  <= ld_row;
            out_act_reg  <= ld_act;
            out_val_reg  <= ld_val;
            out_last_reg <= ld_last;
        end
    end

    // row memory with a registered read
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[a_row][{a_byte, 3'b000} +: 8] <= in_data;
        end
        if (rd_en) begin
            ram_q_reg <= mem[rd_row];
            vld_q_reg <= vld_reg[{rd_row, 3'b000} +: 8];
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {5'd0, out_val_reg, out_act_reg, out_row_reg};
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

endmodule
